@@ rtl/core/tdpt_pkg.sv @@
// Shared constants and types for the trial-division prime test core.
package tdpt_pkg;

  localparam int VALUE_BITS = 32;
  localparam int SQ_BITS    = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(VALUE_BITS);
  localparam int STATE_BITS = 3;

  localparam logic [STATE_BITS-1:0] ST_IDLE  = 3'd0;
  localparam logic [STATE_BITS-1:0] ST_CLASS = 3'd1;
  localparam logic [STATE_BITS-1:0] ST_TEST  = 3'd2;
  localparam logic [STATE_BITS-1:0] ST_WAIT  = 3'd3;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_res_t;

endpackage

@@ rtl/core/tdpt_rem.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module tdpt_rem (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            go,
  input  logic [tdpt_pkg::VALUE_BITS-1:0] dividend,
  input  logic [tdpt_pkg::VALUE_BITS-1:0] divisor,
  output tdpt_pkg::rem_res_t              res
);

  logic                            active_r;
  logic                            done_r;
  logic [tdpt_pkg::CNT_BITS-1:0]   cnt_r;
  logic [tdpt_pkg::VALUE_BITS-1:0] sh_r;
  logic [tdpt_pkg::VALUE_BITS-1:0] rem_r;
  logic [tdpt_pkg::VALUE_BITS:0]   trial;
  logic [tdpt_pkg::VALUE_BITS:0]   dvs_ext;
  logic [tdpt_pkg::VALUE_BITS-1:0] rem_nxt;

  assign trial   = {rem_r, sh_r[tdpt_pkg::VALUE_BITS-1]};
  assign dvs_ext = {1'b0, divisor};

  always_comb begin
    if (trial >= dvs_ext) begin
      rem_nxt = tdpt_pkg::VALUE_BITS'(trial - dvs_ext);
    end else begin
      rem_nxt = trial[tdpt_pkg::VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        active_r <= 1'b1;
        cnt_r    <= tdpt_pkg::CNT_BITS'(tdpt_pkg::VALUE_BITS - 1);
      end else if (active_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      sh_r  <= dividend;
      rem_r <= '0;
    end else if (active_r) begin
      sh_r  <= {sh_r[tdpt_pkg::VALUE_BITS-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign res.done = done_r;
  assign res.zero = (rem_r == '0);

endmodule

@@ rtl/core/trial_division_prime_test_core.sv @@
// Top level of the trial-division prime test core.
//
// Pulse start while busy is low to hand over in_candidate (signed, VALUE_BITS
// wide); that edge is the transfer. When the test finishes, out_valid is high
// for exactly one cycle with out_tested_value (the candidate echoed) and
// out_prime_flag; the receiver cannot stall, so it must take the result in
// that cycle. busy is already low in the cycle the result is shown, so the
// next candidate may be started then. Negative values, 0, 1 and all even
// values, 2 among them, are settled in the classify state. Odd candidates
// try divisors 3, 5, 7, ... while d*d <= n; each divisor is checked by the
// bit-serial remainder unit that shifts in one dividend bit per cycle. d*d
// is kept incrementally ((d+2)^2 = d^2 + 4d + 4), so no multiplier is
// needed.
module trial_division_prime_test_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tdpt_pkg::VALUE_BITS-1:0] in_candidate,
  output logic                                   out_valid,
  output logic signed [tdpt_pkg::VALUE_BITS-1:0] out_tested_value,
  output logic                                   out_prime_flag
);

  localparam int W = tdpt_pkg::VALUE_BITS;

  logic [tdpt_pkg::STATE_BITS-1:0] state_r;
  logic [W-1:0]                    n_r;       // candidate under test
  logic [W-1:0]                    d_r;       // current odd divisor
  logic [tdpt_pkg::SQ_BITS-1:0]    sq_r;      // d_r squared
  logic                            out_valid_r;
  logic [W-1:0]                    out_value_r;
  logic                            out_flag_r;
  logic                            accept;
  logic                            rem_go;
  logic                            over_bound;
  tdpt_pkg::rem_res_t              rem_res;

  assign accept     = start && !busy;
  assign busy       = (state_r != tdpt_pkg::ST_IDLE);
  assign rem_go     = (state_r == tdpt_pkg::ST_TEST) && !over_bound;
  assign over_bound = (sq_r > {1'b0, n_r});

  tdpt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (rem_go),
    .dividend (n_r),
    .divisor  (d_r),
    .res      (rem_res)
  );

  // Control: state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tdpt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        tdpt_pkg::ST_IDLE: begin
          if (accept) begin
            state_r <= tdpt_pkg::ST_CLASS;
          end
        end
        tdpt_pkg::ST_CLASS: begin
          // negative, 0, 1, 2 and even values settle here
          if (n_r[W-1] || (n_r[W-1:1] == '0) || !n_r[0]) begin
            state_r     <= tdpt_pkg::ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= tdpt_pkg::ST_TEST;
          end
        end
        tdpt_pkg::ST_TEST: begin
          if (over_bound) begin
            state_r     <= tdpt_pkg::ST_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            state_r <= tdpt_pkg::ST_WAIT;
          end
        end
        tdpt_pkg::ST_WAIT: begin
          if (rem_res.done) begin
            if (rem_res.zero) begin
              state_r     <= tdpt_pkg::ST_IDLE;
              out_valid_r <= 1'b1;
            end else begin
              state_r <= tdpt_pkg::ST_TEST;
            end
          end
        end
        default: begin
          state_r <= tdpt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: candidate, divisor, square and result payload
  always_ff @(posedge clk) begin
    case (state_r)
      tdpt_pkg::ST_IDLE: begin
        if (accept) begin
          n_r <= in_candidate;
        end
      end
      tdpt_pkg::ST_CLASS: begin
        d_r         <= W'(3);
        sq_r        <= tdpt_pkg::SQ_BITS'(9);
        out_value_r <= n_r;
        // only 2 is prime among the trivial cases
        out_flag_r  <= (n_r == W'(2));
      end
      tdpt_pkg::ST_TEST: begin
        // bound passed with no divisor found: prime
        out_flag_r <= 1'b1;
      end
      tdpt_pkg::ST_WAIT: begin
        if (rem_res.done) begin
          out_flag_r <= 1'b0;
          d_r        <= d_r + W'(2);
          sq_r       <= sq_r + tdpt_pkg::SQ_BITS'({d_r, 2'b00}) + tdpt_pkg::SQ_BITS'(4);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_tested_value = out_value_r;
  assign out_prime_flag   = out_flag_r;

  // The block is back in idle whenever a result is shown
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A transfer always starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("transfer did not start work");

  // Remainder completions arrive only while waiting for them
  a_rem_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_res.done |-> (state_r == tdpt_pkg::ST_WAIT))
    else $error("stray remainder completion");

  // A prime is never negative
  a_prime_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prime_flag) |-> !out_tested_value[W-1])
    else $error("negative value flagged prime");

  // The only even prime is 2
  a_even_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_prime_flag && !out_tested_value[0]) |->
      (out_tested_value == W'(2)))
    else $error("even value other than 2 flagged prime");

endmodule

@@ tb/tdpt_result_checker.sv @@
// Result checker for the trial-division prime test core: predicts each verdict and compares.
`timescale 1ns / 1ps

module tdpt_result_checker (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic                                   busy,
  input  logic signed [tdpt_pkg::VALUE_BITS-1:0] in_candidate,
  input  logic                                   out_valid,
  input  logic signed [tdpt_pkg::VALUE_BITS-1:0] out_tested_value,
  input  logic                                   out_prime_flag,
  output int                                     mismatch_count,
  output int                                     pending_verdicts,
  output int                                     checked_count,
  output int                                     prime_count
);

  typedef struct {
    logic signed [tdpt_pkg::VALUE_BITS-1:0] value;
    logic                                   prime_bit;
  } verdict_t;

  verdict_t verdict_q[$];

  // Trial division with the bound kept as d <= n / d, so nothing overflows.
  function automatic logic predict_prime(input logic [tdpt_pkg::VALUE_BITS-1:0] raw);
    longint unsigned n;
    longint unsigned d;
    n = raw;
    if (raw[tdpt_pkg::VALUE_BITS-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    if (n == 2) return 1'b1;
    if (!raw[0]) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t entry;
    if (!rst_n) begin
      mismatch_count   <= 0;
      pending_verdicts <= 0;
      checked_count    <= 0;
      prime_count      <= 0;
    end else begin
      // A result leaving in the same cycle as a new transfer belongs to the older item.
      if (out_valid) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got value %0d flag %0b",
                   $time, out_tested_value, out_prime_flag);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (out_tested_value !== want.value || out_prime_flag !== want.prime_bit) begin
            $display("%0t: mismatch: expected value %0d flag %0b, got value %0d flag %0b",
                     $time, want.value, want.prime_bit, out_tested_value, out_prime_flag);
            mismatch_count <= mismatch_count + 1;
          end
          checked_count <= checked_count + 1;
          if (want.prime_bit) prime_count <= prime_count + 1;
        end
      end
      if (start && !busy) begin
        entry.value     = in_candidate;
        entry.prime_bit = predict_prime(in_candidate);
        verdict_q.push_back(entry);
      end
      pending_verdicts <= verdict_q.size();
    end
  end

endmodule

@@ tb/tb_trial_division_prime_test_core.sv @@
// Testbench top for the trial-division prime test core: stimulus, timeout and verdict.
`timescale 1ns / 1ps

module tb_trial_division_prime_test_core;

  // Worst run is dominated by the single largest 32-bit prime; every other
  // item is far cheaper, so the whole run stays well under CYCLE_LIMIT even
  // if every random item were the slowest kind.
  localparam int CYCLE_LIMIT  = 10_000_000;
  localparam int RANDOM_ITEMS = 77;
  localparam int NUM_DIRECTED = 23;

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   start = 1'b0;
  logic                                   busy;
  logic signed [tdpt_pkg::VALUE_BITS-1:0] in_candidate = '0;
  logic                                   out_valid;
  logic signed [tdpt_pkg::VALUE_BITS-1:0] out_tested_value;
  logic                                   out_prime_flag;

  int mismatch_count;
  int pending_verdicts;
  int checked_count;
  int prime_count;
  int cycle_count = 0;
  int sent_count = 0;

  // Directed candidates: field extremes, the small special values, perfect
  // squares where d*d lands exactly on n, and a few primes of growing size.
  logic signed [tdpt_pkg::VALUE_BITS-1:0] directed_vals [NUM_DIRECTED] = '{
    32'sh8000_0000,  // most negative
    -32'sd1,
    32'sd0,
    32'sd1,
    32'sd2,          // only even prime
    32'sd3,
    32'sd4,
    32'sd5,
    32'sd9,          // 3*3: bound hits equality on the first divisor
    32'sd15,
    32'sd25,
    32'sd49,
    32'sd97,
    32'sd121,
    32'sd65521,
    32'sd65537,
    32'sd1000003,
    32'sd1022117,    // 1009*1013: factor found late
    32'sh5555_5555,  // alternating bits, divisible by 5
    32'shAAAA_AAAA,  // alternating bits, negative
    32'sh7FFF_FFFE,  // large even
    32'sh7FFF_FFFD,  // large odd, divisible by 5
    32'sh7FFF_FFFF   // most positive, also prime: the slowest case
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  trial_division_prime_test_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_tested_value (out_tested_value),
    .out_prime_flag   (out_prime_flag)
  );

  tdpt_result_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_candidate     (in_candidate),
    .out_valid        (out_valid),
    .out_tested_value (out_tested_value),
    .out_prime_flag   (out_prime_flag),
    .mismatch_count   (mismatch_count),
    .pending_verdicts (pending_verdicts),
    .checked_count    (checked_count),
    .prime_count      (prime_count)
  );

  // Hard stop in case the core hangs or a result never shows up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_verdicts);
      $display("trial_division_prime_test_core verification failed");
      $finish;
    end
  end

  // Called right after a rising edge. Raises start with the candidate and
  // returns just after the edge that made the transfer. start is left high
  // so a back-to-back item simply swaps the data without a low cycle.
  task automatic send_candidate(input logic signed [tdpt_pkg::VALUE_BITS-1:0] value);
    start        <= 1'b1;
    in_candidate <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent_count++;
  endtask

  // Sender idle stretch; called right after a transfer edge.
  task automatic sender_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every outstanding verdict has come back. The checker's
  // count is registered, so the loop steps the clock before looking at it.
  task automatic drain_verdicts();
    start <= 1'b0;
    do @(posedge clk); while (pending_verdicts != 0);
  endtask

  // Random candidate mix. Negatives and evens are settled in the classify
  // state, so they carry the full 32-bit range. Odd positives are kept small,
  // or built as multiples of a tiny prime, so no item comes near the cost
  // of the largest primes while the upper bits still get exercised.
  function automatic logic signed [tdpt_pkg::VALUE_BITS-1:0] pick_candidate();
    int unsigned roll;
    int unsigned factor;
    int unsigned k;
    roll = $urandom_range(99);
    if (roll < 20) begin
      return {1'b1, (tdpt_pkg::VALUE_BITS-1)'($urandom)};
    end else if (roll < 40) begin
      return $urandom & 32'h7FFF_FFFE;
    end else if (roll < 55) begin
      // large odd composite with a small factor
      factor = ($urandom_range(1) == 0) ? 3 : 5;
      k = $urandom_range(32'h7FFF_FFFF / factor - 1) | 1;
      return factor * k;
    end else if (roll < 62) begin
      return $urandom_range(16);
    end else if (roll < 95) begin
      return $urandom_range(65535, 3) | 1;
    end else begin
      return $urandom_range(1 << 20, 65537) | 1;
    end
  endfunction

  initial begin
    int i;
    // synchronous reset: hold rst_n low, then release
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the usual sender gaps sprinkled in.
    for (i = 0; i < NUM_DIRECTED; i++) begin
      send_candidate(directed_vals[i]);
      if ($urandom_range(99) < 26) sender_gap($urandom_range(30, 1));
    end

    // Pressure point: let the core run completely dry before the random part.
    drain_verdicts();

    // Random part. Items 30..59 go back to back, with no sender gaps at all.
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      send_candidate(pick_candidate());
      if (i == 75) begin
        drain_verdicts();
      end else if ((i < 30 || i >= 60) && $urandom_range(99) < 26) begin
        sender_gap($urandom_range(40, 1));
      end
    end

    // Wind down: wait for the last verdict, then a short quiet tail so any
    // stray extra strobe would still be caught.
    drain_verdicts();
    repeat (50) @(posedge clk);

    $display("Covered %0d candidates (%0d directed), %0d verdicts checked, %0d prime",
             sent_count, NUM_DIRECTED, checked_count, prime_count);
    $display("Mix: negatives, zero/one/two, evens, small and mid odds, and 32-bit extremes");
    if (mismatch_count == 0 && pending_verdicts == 0) begin
      $display("trial_division_prime_test_core verification clean");
    end else begin
      $display("%0d mismatches, %0d verdicts never returned", mismatch_count, pending_verdicts);
      $display("trial_division_prime_test_core verification failed");
    end
    $finish;
  end

endmodule
